// ----- design/sqsb_pkg.sv -----
package sqsb_pkg;

  // Store geometry
  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);

  // Stream widths
  localparam int OP_W       = 2;
  localparam int IN_RAW_W   = OP_W + DATA_W;
  localparam int IN_TDATA_W = ((IN_RAW_W + 7) / 8) * 8;
  localparam int KIND_W     = 2;
  localparam int OUT_USER_W = KIND_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_STACK  = 2'd2,
    OP_QUEUE  = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_REMOVED = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_DUMP    = 2'd2,
    KIND_FULL    = 2'd3
  } kind_e;

  // Result description issued alongside a memory read (or without one)
  typedef struct packed {
    kind_e kind;
    logic  empty_dump;
    logic  last;
    logic  use_ram;
  } res_meta_t;

  // One finished result waiting for the output side
  typedef struct packed {
    kind_e                    kind;
    logic                     empty_dump;
    logic                     last;
    logic signed [DATA_W-1:0] data;
  } res_item_t;

endpackage

// ----- design/sqsb_ram.sv -----
module sqsb_ram #(
  parameter int Width = sqsb_pkg::DATA_W,
  parameter int Depth = sqsb_pkg::DEPTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/stack_queue_switchable_buffer_unit.sv -----
// Channel   Direction  Signals                  Contents (lowest bit first)
// s_axis    in         tvalid tready tdata      tdata: opcode[1:0], value[33:2], zero fill
// m_axis    out        tvalid tready tdata      tdata: data[31:0]
//                      tuser tlast              tuser: kind[1:0], empty_dump[2]; tlast: last
//
// The memory reads at the transfer edge itself, so a removed word sits in the memory read
// register behind the read stage, then moves to the output register or its skid stage and
// leaves from there.
// A mode switch on a non-empty store enters the dump state and streams one element per cycle
// while the output buffer has room, paced by the single read port of the store memory.
// Input is held off while a dump runs, or while two results already sit in the read stage,
// the output register and its skid stage with none leaving this cycle. Reset clears
// pointers, count and mode (stack mode); the store memory is not cleared and needs no
// pass after reset.
module stack_queue_switchable_buffer_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // opcode [1:0], value [33:2], zeros above
  input  logic [sqsb_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // data [31:0]
  output logic [sqsb_pkg::DATA_W-1:0]           m_axis_tdata_o,
  // kind [1:0], empty_dump [2]
  output logic [sqsb_pkg::OUT_USER_W-1:0]       m_axis_tuser_o,
  output logic                                  m_axis_tlast_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  localparam int IDX_W  = sqsb_pkg::IDX_W;
  localparam int CNT_W  = sqsb_pkg::CNT_W;
  localparam int DATA_W = sqsb_pkg::DATA_W;

  // Control state
  logic                 state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     front_q, front_d;
  logic                 stack_q, stack_d;
  logic [CNT_W-1:0]     dump_i_q, dump_i_d;

  // Read stage and output buffer
  logic                 st1_v_q, st1_v_d;
  sqsb_pkg::res_meta_t  st1_meta_q, st1_meta_d;
  logic                 out_v_q, out_v_d;
  logic                 skid_v_q, skid_v_d;
  sqsb_pkg::res_item_t  out_q, out_d;
  sqsb_pkg::res_item_t  skid_q, skid_d;
  sqsb_pkg::res_item_t  st1_item;

  // Memory port
  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0]    ram_rdata;

  // Decode and ring arithmetic
  sqsb_pkg::op_e        opcode;
  logic [DATA_W-1:0]    value;
  logic                 deq, issue_ok, in_acc, full, empty, dump_last;
  logic [1:0]           occ;
  logic [CNT_W-1:0]     dump_off, off_sel;
  logic [IDX_W:0]       ring_sum;
  logic [IDX_W-1:0]     ring_pos, front_inc;

  assign opcode = sqsb_pkg::op_e'(s_axis_tdata_i[sqsb_pkg::OP_W-1:0]);
  assign value  = s_axis_tdata_i[sqsb_pkg::IN_RAW_W-1:sqsb_pkg::OP_W];

  assign full  = (count_q == sqsb_pkg::DEPTH_CNT);
  assign empty = (count_q == '0);

  // Output handshake and room for one more issued result
  assign deq = out_v_q & m_axis_tready_i;
  assign occ = 2'({1'b0, out_v_q}) + 2'({1'b0, skid_v_q}) + 2'({1'b0, st1_v_q})
             - 2'({1'b0, deq});
  assign issue_ok = (occ <= 2'd1);

  assign s_axis_tready_o = (state_q == ST_IDLE) && issue_ok;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Ring position: front plus offset, one wrap
  assign dump_off  = stack_q ? (count_q - CNT_W'(1) - dump_i_q) : dump_i_q;
  assign dump_last = (dump_i_q + CNT_W'(1) == count_q);

  always_comb begin
    if (state_q == ST_DUMP) begin
      off_sel = dump_off;
    end else if (opcode == sqsb_pkg::OP_INSERT) begin
      off_sel = count_q;
    end else if (stack_q) begin
      off_sel = count_q - CNT_W'(1);
    end else begin
      off_sel = '0;
    end
  end

  assign ring_sum = {1'b0, front_q} + {1'b0, off_sel[IDX_W-1:0]};
  assign ring_pos = (ring_sum >= (IDX_W+1)'(sqsb_pkg::DEPTH))
                  ? IDX_W'(ring_sum - (IDX_W+1)'(sqsb_pkg::DEPTH))
                  : ring_sum[IDX_W-1:0];
  assign front_inc = (front_q == sqsb_pkg::IDX_LAST) ? '0 : front_q + IDX_W'(1);

  assign ram_waddr = ring_pos;
  assign ram_raddr = ring_pos;

  // Sequencer: accept an operation, or step a dump one element per cycle while the output has room
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    front_d    = front_q;
    stack_d    = stack_q;
    dump_i_d   = dump_i_q;
    st1_v_d    = 1'b0;
    st1_meta_d = '{kind: sqsb_pkg::KIND_REMOVED, empty_dump: 1'b0, last: 1'b1,
                   use_ram: 1'b0};
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (opcode)
            sqsb_pkg::OP_INSERT: begin
              if (full) begin
                st1_v_d         = 1'b1;
                st1_meta_d.kind = sqsb_pkg::KIND_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            sqsb_pkg::OP_REMOVE: begin
              st1_v_d = 1'b1;
              if (empty) begin
                st1_meta_d.kind = sqsb_pkg::KIND_EMPTY;
              end else begin
                ram_re             = 1'b1;
                st1_meta_d.use_ram = 1'b1;
                count_d            = count_q - CNT_W'(1);
                if (!stack_q) begin
                  front_d = front_inc;
                end
              end
            end
            default: begin
              stack_d = (opcode == sqsb_pkg::OP_STACK);
              if (empty) begin
                st1_v_d               = 1'b1;
                st1_meta_d.kind       = sqsb_pkg::KIND_DUMP;
                st1_meta_d.empty_dump = 1'b1;
              end else begin
                state_d  = ST_DUMP;
                dump_i_d = '0;
              end
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (issue_ok) begin
          ram_re             = 1'b1;
          st1_v_d            = 1'b1;
          st1_meta_d.kind    = sqsb_pkg::KIND_DUMP;
          st1_meta_d.last    = dump_last;
          st1_meta_d.use_ram = 1'b1;
          dump_i_d           = dump_i_q + CNT_W'(1);
          if (dump_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result leaving the read stage
  assign st1_item.kind       = st1_meta_q.kind;
  assign st1_item.empty_dump = st1_meta_q.empty_dump;
  assign st1_item.last       = st1_meta_q.last;
  assign st1_item.data       = st1_meta_q.use_ram ? ram_rdata : '0;

  // Output register with skid stage, kept in order
  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (!out_v_q || deq) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_d   = st1_item;
        skid_v_d = st1_v_q;
      end else begin
        out_d    = st1_item;
        out_v_d  = st1_v_q;
      end
    end else if (st1_v_q) begin
      skid_d   = st1_item;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      front_q  <= '0;
      stack_q  <= 1'b1;
      dump_i_q <= '0;
      st1_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      front_q  <= front_d;
      stack_q  <= stack_d;
      dump_i_q <= dump_i_d;
      st1_v_q  <= st1_v_d;
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    st1_meta_q <= st1_meta_d;
    out_q      <= out_d;
    skid_q     <= skid_d;
  end

  // Store memory; writes and reads never share a cycle
  sqsb_ram #(
    .Width (DATA_W),
    .Depth (sqsb_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q.data;
  assign m_axis_tuser_o  = {out_q.empty_dump, out_q.kind};
  assign m_axis_tlast_o  = out_q.last;

`ifndef SYNTHESIS
  // Skid stage only fills behind a held output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage valid while output register empty");

  // An arriving result always finds room
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st1_v_q |-> !(out_v_q && skid_v_q && !m_axis_tready_i))
    else $error("result arrived with output buffer full");

  // Count stays within the ring
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sqsb_pkg::DEPTH_CNT)
    else $error("count beyond store depth");

  // A dump leaves count and front untouched
  a_dump_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |=> ($stable(count_q) && $stable(front_q)))
    else $error("count or front moved during a dump");
`endif

endmodule

// ----- sim/deque_scoreboard_pkg.sv -----
package deque_scoreboard_pkg;

  import sqsb_pkg::*;

  // One result as it should leave the output stream
  typedef struct {
    kind_e                    kind;
    logic signed [DATA_W-1:0] data;
    logic                     empty_dump;
    logic                     last;
  } deque_result_t;

  class deque_scoreboard;

    // Shadow of the ring store, its front position, fill level and mode
    logic signed [DATA_W-1:0] words [DEPTH];
    int unsigned              head;
    int unsigned              fill;
    bit                       lifo;

    deque_result_t            pending [$];
    int                       failures;

    function new();
      head     = 0;
      fill     = 0;
      lifo     = 1'b1;
      failures = 0;
    endfunction

    function int unsigned slot(int unsigned off);
      return (head + off) % DEPTH;
    endfunction

    function void push(kind_e k, logic signed [DATA_W-1:0] d, logic e, logic l);
      deque_result_t r;
      r.kind       = k;
      r.data       = d;
      r.empty_dump = e;
      r.last       = l;
      pending.push_back(r);
    endfunction

    // Emit the contents top to bottom as a stack, front to rear as a queue
    function void dump_contents();
      int unsigned i;
      if (fill == 0) begin
        push(KIND_DUMP, '0, 1'b1, 1'b1);
      end else begin
        for (i = 0; i < fill; i++) begin
          push(KIND_DUMP, words[slot(lifo ? fill - 1 - i : i)], 1'b0, (i + 1 == fill));
        end
      end
    endfunction

    // Advance the shadow state by one accepted command and queue its results
    function void note_command(op_e op, logic signed [DATA_W-1:0] value);
      case (op)
        OP_INSERT: begin
          if (fill >= DEPTH) begin
            push(KIND_FULL, '0, 1'b0, 1'b1);
          end else begin
            words[slot(fill)] = value;
            fill++;
          end
        end
        OP_REMOVE: begin
          if (fill == 0) begin
            push(KIND_EMPTY, '0, 1'b0, 1'b1);
          end else if (lifo) begin
            push(KIND_REMOVED, words[slot(fill - 1)], 1'b0, 1'b1);
            fill--;
          end else begin
            push(KIND_REMOVED, words[head], 1'b0, 1'b1);
            head = slot(1);
            fill--;
          end
        end
        OP_STACK: begin
          lifo = 1'b1;
          dump_contents();
        end
        default: begin
          lifo = 1'b0;
          dump_contents();
        end
      endcase
    endfunction

    function int unsigned held();
      return fill;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    // Compare one output transfer with the oldest outstanding result
    function void check_result(logic [DATA_W-1:0] data, logic [OUT_USER_W-1:0] user,
                               logic last);
      deque_result_t r;
      if (pending.size() == 0) begin
        $error("unexpected result: kind %0d data %0h empty_dump %0b last %0b",
               user[KIND_W-1:0], data, user[KIND_W], last);
        failures++;
        return;
      end
      r = pending.pop_front();
      if (user[KIND_W-1:0] !== r.kind) begin
        $error("kind: expected %0d, actual %0d", r.kind, user[KIND_W-1:0]);
        failures++;
      end
      if (data !== r.data) begin
        $error("data: expected %0h, actual %0h", r.data, data);
        failures++;
      end
      if (user[KIND_W] !== r.empty_dump) begin
        $error("empty_dump: expected %0b, actual %0b", r.empty_dump, user[KIND_W]);
        failures++;
      end
      if (last !== r.last) begin
        $error("last: expected %0b, actual %0b", r.last, last);
        failures++;
      end
    endfunction

    // Flag anything never delivered and return the total failure count
    function int close_out();
      if (pending.size() != 0) begin
        $error("%0d results never arrived", pending.size());
        failures += pending.size();
      end
      return failures;
    endfunction

  endclass

endpackage

// ----- sim/tb_top.sv -----
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import sqsb_pkg::*;
  import deque_scoreboard_pkg::*;

  localparam int HOLD_CYCLES = 200;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    s_axis_tvalid_i;
  logic                    s_axis_tready_o;
  // opcode [1:0], value [33:2], zeros above
  logic [IN_TDATA_W-1:0]   s_axis_tdata_i;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i;
  // data [31:0]
  logic [DATA_W-1:0]       m_axis_tdata_o;
  // kind [1:0], empty_dump [2]
  logic [OUT_USER_W-1:0]   m_axis_tuser_o;
  logic                    m_axis_tlast_o;

  deque_scoreboard sb;
  bit              no_gaps;
  bit              hold_off_req;

  stack_queue_switchable_buffer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Offer one command, hold it until the transfer, then note it
  task automatic send_item(input op_e op, input logic signed [DATA_W-1:0] value);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_TDATA_W - IN_RAW_W){1'b0}}, value, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(op, value);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_word();
    logic signed [DATA_W-1:0] w;
    case ($urandom_range(0, 7))
      0:       w = {1'b1, {(DATA_W - 1){1'b0}}};
      1:       w = {1'b0, {(DATA_W - 1){1'b1}}};
      2:       w = '0;
      3:       w = '1;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Draw a command with the given share of inserts
  task automatic send_random(input int unsigned insert_pct);
    int unsigned r;
    op_e         op;
    r = $urandom_range(0, 99);
    if (r < insert_pct) begin
      op = OP_INSERT;
    end else begin
      r  = $urandom_range(0, 99);
      op = (r < 70) ? OP_REMOVE : (r < 85) ? OP_STACK : OP_QUEUE;
    end
    send_item(op, pick_word());
  endtask

  // Output side: random back-pressure, one long hold-off on request
  initial begin
    int gap;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        gap          = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 3);
      end
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    end
  end

  // Reset, directed commands, random phases, drain
  initial begin
    int unsigned insert_pct [5];
    int          p;
    int          n;
    insert_pct      = '{60, 95, 25, 70, 40};
    sb              = new();
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    no_gaps         = 1'b0;
    hold_off_req    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty store: remove and both dumps
    send_item(OP_REMOVE, 32'sd7);
    send_item(OP_STACK, '1);
    send_item(OP_QUEUE, '0);
    send_item(OP_REMOVE, '1);
    // Extreme words, then dump and remove in both modes
    send_item(OP_INSERT, 32'h7fff_ffff);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hffff_ffff);
    send_item(OP_INSERT, 32'h5555_5555);
    send_item(OP_QUEUE, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_STACK, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_INSERT, 32'haaaa_aaaa);
    send_item(OP_QUEUE, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_STACK, '0);

    for (p = 0; p < 5; p++) begin
      no_gaps = (p == 3);
      // Stall the output while removes and dumps pile up
      if (p == 2) hold_off_req = 1'b1;
      for (n = 0; n < 40; n++) send_random(insert_pct[p]);
      // Fill to the brim, then overflow
      if (p == 1) begin
        while (sb.held() < DEPTH) send_item(OP_INSERT, pick_word());
        send_item(OP_INSERT, pick_word());
        send_item(OP_INSERT, pick_word());
        send_item(OP_STACK, pick_word());
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.close_out() == 0) begin
      $display("stack_queue_switchable_buffer_unit regression: pass");
    end else begin
      $display("stack_queue_switchable_buffer_unit regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("stack_queue_switchable_buffer_unit regression: fail");
    $finish;
  end

endmodule
